// File: sv/ssms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment message scanner package
// Item types, character glyph table, frame timing constants and helpers.
// ----------------------------------------------------------------------------
package ssms_pkg;

  localparam int MESSAGE_CHARS_DEF = 20;
  localparam int CHAR_W            = 8;
  localparam int DIGITS            = 4;
  localparam int SLOTS_PER_FRAME   = 5;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_Z     = 8'h7A;

  localparam logic [6:0] DWELL_RESET = 7'd25;
  localparam logic [6:0] PAT_DASH    = 7'h40;

  localparam logic [6:0] LETTER_PAT [26] = '{
    7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h6F, 7'h74, 7'h30, 7'h1E, 7'h70, 7'h38,
    7'h15, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78, 7'h3E, 7'h1C, 7'h2A, 7'h46,
    7'h6E, 7'h52
  };

  localparam logic [6:0] DIGIT_PAT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
  };

  typedef struct packed {
    logic       kind;
    logic [4:0] char_position;
    logic [7:0] char_code;
    logic [1:0] speed_select;
  } in_item_t;

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [6:0] segments;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

  function automatic logic [6:0] glyph(input logic [7:0] code);
    logic [7:0] letter_off;
    logic [7:0] digit_off;
    logic [6:0] pat;
    letter_off = code - CHAR_A;
    digit_off  = code - CHAR_0;
    pat        = '0;
    if (code inside {[CHAR_A:CHAR_Z]}) begin
      pat = LETTER_PAT[letter_off[4:0]];
    end else if (code inside {[CHAR_0:CHAR_9]}) begin
      pat = DIGIT_PAT[digit_off[3:0]];
    end else if (code == CHAR_DASH) begin
      pat = PAT_DASH;
    end
    return pat;
  endfunction

  function automatic logic [6:0] dwell_lookup(input logic [1:0] speed);
    logic [6:0] frames;
    case (speed)
      2'd0:    frames = 7'd25;
      2'd1:    frames = 7'd50;
      2'd2:    frames = 7'd75;
      2'd3:    frames = 7'd100;
      default: frames = 7'd25;
    endcase
    return frames;
  endfunction

endpackage

// File: sv/ssms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered under a read enable.
// ----------------------------------------------------------------------------
module ssms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/ssms_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message store
// Character RAM with a written flag per entry; unwritten entries read as a space.
// ----------------------------------------------------------------------------
module ssms_store
  import ssms_pkg::*;
#(
  parameter int MESSAGE_CHARS = MESSAGE_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  store_ctl_t                       ctl,
  input  logic [$clog2(MESSAGE_CHARS)-1:0] wr_addr,
  input  logic [CHAR_W-1:0]                wr_data,
  input  logic [$clog2(MESSAGE_CHARS)-1:0] rd_addr,
  output logic [CHAR_W-1:0]                rd_char
);

  logic [MESSAGE_CHARS-1:0] written_r;
  logic [MESSAGE_CHARS-1:0] written_nxt;
  logic                     rd_written_r;
  logic [CHAR_W-1:0]        ram_q;

  ssms_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MESSAGE_CHARS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    written_nxt = written_r;
    if (ctl.wr_en) begin
      written_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else begin
      written_r <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_written_r <= written_r[rd_addr];
    end
  end

  assign rd_char = rd_written_r ? ram_q : CHAR_SPACE;

endmodule

// File: sv/ssms_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Refresh scan counters
// Slot, frame, group and dwell registers that step once per display tick.
// ----------------------------------------------------------------------------
module ssms_scan
  import ssms_pkg::*;
#(
  parameter int MESSAGE_CHARS = MESSAGE_CHARS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [1:0]                       speed_select,
  output logic [$clog2(MESSAGE_CHARS)-1:0] rd_addr,
  output logic [DIGITS-1:0]                digit_enable
);

  localparam int GROUPS  = MESSAGE_CHARS / 4;
  localparam int GROUP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int ADDR_W  = $clog2(MESSAGE_CHARS);

  logic [2:0]         slot_r;
  logic [2:0]         slot_nxt;
  logic [6:0]         frame_r;
  logic [6:0]         frame_nxt;
  logic [GROUP_W-1:0] group_r;
  logic [GROUP_W-1:0] group_nxt;
  logic [6:0]         dwell_r;
  logic [6:0]         dwell_nxt;
  logic [6:0]         dwell_cur;
  logic               last_slot;
  logic               last_frame;
  logic               last_group;

  always_comb begin
    dwell_cur  = ((slot_r == '0) && (frame_r == '0)) ? dwell_lookup(speed_select) : dwell_r;
    last_slot  = (slot_r == 3'(SLOTS_PER_FRAME - 1));
    last_frame = ((frame_r + 7'd1) >= dwell_cur);
    last_group = (group_r == GROUP_W'(GROUPS - 1));
  end

  always_comb begin
    slot_nxt  = slot_r;
    frame_nxt = frame_r;
    group_nxt = group_r;
    dwell_nxt = dwell_r;
    if (step) begin
      dwell_nxt = dwell_cur;
      slot_nxt  = last_slot ? '0 : slot_r + 3'd1;
      if (last_slot) begin
        frame_nxt = last_frame ? '0 : frame_r + 7'd1;
        if (last_frame) begin
          group_nxt = last_group ? '0 : group_r + GROUP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      frame_r <= '0;
      group_r <= '0;
      dwell_r <= DWELL_RESET;
    end else begin
      slot_r  <= slot_nxt;
      frame_r <= frame_nxt;
      group_r <= group_nxt;
      dwell_r <= dwell_nxt;
    end
  end

  assign rd_addr      = ADDR_W'({group_r, slot_r[1:0]});
  assign digit_enable = (slot_r < 3'(DIGITS)) ? (DIGITS'(1) << slot_r[1:0]) : '0;

endmodule

// File: sv/seven_segment_message_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment message scanner
// Drives a four-digit multiplexed display from a stored character message.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_stall and results leave on out_valid/out_stall.
// A load item writes one character into the message store when its position
// is in range and gives no result; a tick item advances the five-slot refresh
// frame and gives one result: the digit drive and segment pattern for that slot.
// A tick item's result is shown on the output once it has passed through the
// input register, the message RAM read register and the output register. One
// item is accepted every cycle while in_stall is low; the RAM's single read
// port is registered.
// Reset clears the scan counters, marks every message position as blank
// and empties the pipeline; no clearing pass is needed.
// When the receiver stalls, the output holds and the pipeline keeps filling
// any empty stages, so in_stall rises only once no stage can move.
// ----------------------------------------------------------------------------
module seven_segment_message_scanner
  import ssms_pkg::*;
#(
  parameter int MESSAGE_CHARS = MESSAGE_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int ADDR_W = $clog2(MESSAGE_CHARS);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  in_item_t          s1_item_r;
  logic              s2_valid_r;
  logic              s2_valid_nxt;
  logic [DIGITS-1:0] s2_enable_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;

  logic              in_take;
  logic              out_free;
  logic              s2_free;
  logic              s1_is_tick;
  logic              s1_go;
  logic              tick_go;
  store_ctl_t        store_ctl;
  logic [ADDR_W-1:0] rd_addr;
  logic [DIGITS-1:0] scan_enable;
  logic [CHAR_W-1:0] rd_char;

  always_comb begin
    out_free   = !out_valid_r || !out_stall;
    s2_free    = !s2_valid_r || out_free;
    s1_is_tick = (s1_item_r.kind == KIND_TICK);
    s1_go      = s1_valid_r && (!s1_is_tick || s2_free);
    tick_go    = s1_go && s1_is_tick;
    in_stall   = s1_valid_r && !s1_go;
    in_take    = in_valid && !in_stall;
    store_ctl.wr_en = s1_go && !s1_is_tick &&
                      (32'(s1_item_r.char_position) < MESSAGE_CHARS);
    store_ctl.rd_en = tick_go;
  end

  ssms_scan #(
    .MESSAGE_CHARS (MESSAGE_CHARS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (tick_go),
    .speed_select (s1_item_r.speed_select),
    .rd_addr      (rd_addr),
    .digit_enable (scan_enable)
  );

  ssms_store #(
    .MESSAGE_CHARS (MESSAGE_CHARS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (store_ctl),
    .wr_addr (ADDR_W'(s1_item_r.char_position)),
    .wr_data (s1_item_r.char_code),
    .rd_addr (rd_addr),
    .rd_char (rd_char)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end

    s2_valid_nxt = s2_valid_r;
    if (tick_go) begin
      s2_valid_nxt = 1'b1;
    end else if (out_free) begin
      s2_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s2_valid_r;
    end

    out_data_nxt.digit_enable = s2_enable_r;
    out_data_nxt.segments     = (s2_enable_r == '0) ? '0 : glyph(rd_char);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (tick_go) begin
      s2_enable_r <= scan_enable;
    end
    if (s2_valid_r && out_free) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_data_r.digit_enable))
    else $error("digit enable is not one-hot or zero");

  a_blank_when_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.digit_enable == '0)) |-> (out_data_r.segments == '0))
    else $error("segments lit in the all-off slot");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_is_tick && s2_valid_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

  a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_free) |=> (s2_valid_r && $stable(s2_enable_r)))
    else $error("read stage lost an item while the output was blocked");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r && !s2_valid_r))
    else $error("pipeline not empty after reset");

endmodule
